/* design/pitch_comb_postfilter_assert.svh */
// Assertion macros shared by the pitch comb postfilter RTL.
`ifndef PITCH_COMB_POSTFILTER_ASSERT_SVH
`define PITCH_COMB_POSTFILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define PCP_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pitch_comb_postfilter: property failed");
// Condition in the cycle after a trigger, outside reset.
`define PCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pitch_comb_postfilter: next-cycle property failed");
`else
`define PCP_ASSERT_RST(lbl, clk, rst, prop)
`define PCP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* design/pcp_pkg.sv */
// Shared types and constants for the pitch comb postfilter.
package pcp_pkg;

   localparam int PERIOD_BITS   = 11;
   localparam int GAIN_BITS     = 16;
   localparam int GAIN_FRAC     = 14;
   localparam int PERIOD_MIN    = 15;
   localparam int PERIOD_MAX    = 1024;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_LSB   = 2;

   typedef logic [CSR_ADDR_BITS-REG_IDX_LSB-1:0] reg_idx_type;

   localparam reg_idx_type REG_PITCH_PERIOD = 2'd0;
   localparam reg_idx_type REG_GAIN_CENTER  = 2'd1;
   localparam reg_idx_type REG_GAIN_INNER   = 2'd2;
   localparam reg_idx_type REG_GAIN_OUTER   = 2'd3;

   typedef logic [2:0] reload_step_type;

   // Five history reads refill the tap window; the last step index.
   localparam reload_step_type RELOAD_LAST = 3'd4;

   typedef enum logic {
      CTL_RUN,
      CTL_RELOAD
   } ctl_state_type;

endpackage

/* design/pcp_req_if.sv */
// Input sample channel of the pitch comb postfilter.
interface pcp_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

/* design/pcp_rsp_if.sv */
// Result sample channel of the pitch comb postfilter.
interface pcp_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* design/pitch_comb_postfilter.sv */
// Pitch comb postfilter top level: recursive 5-tap comb over a ring of past outputs.
// An accepted item is registered in stage 1, then in stage 2, which drives rsp_bus.valid.
// Throughput: one item per cycle barring output stall or refill; one history read each.
// A pitch_period write starts a window refill (five history reads) with ready low.
// Reset (synchronous, active high) clears pointers, fill count, window and valids; the
// history RAM is not swept: a fill count makes never-written entries read as zero.
`include "pitch_comb_postfilter_assert.svh"

module pitch_comb_postfilter #(
   parameter int HISTORY_DEPTH = 2048,
   parameter int SAMPLE_BITS   = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   pcp_req_if.sink                            req_bus,
   pcp_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pcp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [pcp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [pcp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(HISTORY_DEPTH);     // ring index
   localparam int CW  = $clog2(HISTORY_DEPTH + 1); // fill count, holds the depth itself
   localparam int OW  = AW + 2;                    // address sum before wrap
   localparam int VW  = CW + 2;                    // fill compare
   localparam int PCW = SB + pcp_pkg::GAIN_BITS;       // center product
   localparam int PPW = SB + pcp_pkg::GAIN_BITS + 1;   // tap-pair products
   localparam int ACW = SB + pcp_pkg::GAIN_BITS + 3;   // full-precision sum
   localparam int RW  = ACW - pcp_pkg::GAIN_FRAC;      // after rounding shift
   localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'(1) << (pcp_pkg::GAIN_FRAC - 1);

   // ------------------------------------------------------------------
   // Configuration registers (APB, zero wait state)
   // ------------------------------------------------------------------
   logic [pcp_pkg::PERIOD_BITS-1:0]      pitch_period_ff;
   logic signed [pcp_pkg::GAIN_BITS-1:0] gain_center_ff;
   logic signed [pcp_pkg::GAIN_BITS-1:0] gain_inner_ff;
   logic signed [pcp_pkg::GAIN_BITS-1:0] gain_outer_ff;
   pcp_pkg::reg_idx_type                 csr_idx;
   logic                                 csr_wr;
   logic                                 pitch_wr;

   assign pready   = 1'b1;
   assign csr_idx  = paddr[pcp_pkg::CSR_ADDR_BITS-1:pcp_pkg::REG_IDX_LSB];
   assign csr_wr   = psel && penable && pwrite;
   assign pitch_wr = csr_wr && (csr_idx == pcp_pkg::REG_PITCH_PERIOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_period_ff <= pcp_pkg::PERIOD_BITS'(pcp_pkg::PERIOD_MIN);
         gain_center_ff  <= '0;
         gain_inner_ff   <= '0;
         gain_outer_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            pcp_pkg::REG_PITCH_PERIOD: pitch_period_ff <= pwdata[pcp_pkg::PERIOD_BITS-1:0];
            pcp_pkg::REG_GAIN_CENTER:  gain_center_ff  <= pwdata[pcp_pkg::GAIN_BITS-1:0];
            pcp_pkg::REG_GAIN_INNER:   gain_inner_ff   <= pwdata[pcp_pkg::GAIN_BITS-1:0];
            pcp_pkg::REG_GAIN_OUTER:   gain_outer_ff   <= pwdata[pcp_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pcp_pkg::REG_PITCH_PERIOD: prdata = pcp_pkg::CSR_DATA_BITS'(pitch_period_ff);
         pcp_pkg::REG_GAIN_CENTER:  prdata = pcp_pkg::CSR_DATA_BITS'($unsigned(gain_center_ff));
         pcp_pkg::REG_GAIN_INNER:   prdata = pcp_pkg::CSR_DATA_BITS'($unsigned(gain_inner_ff));
         pcp_pkg::REG_GAIN_OUTER:   prdata = pcp_pkg::CSR_DATA_BITS'($unsigned(gain_outer_ff));
         default:                   prdata = '0;
      endcase
   end

   // Period in force: out-of-range settings clamp, the register keeps its bits.
   logic [pcp_pkg::PERIOD_BITS-1:0] period_eff;

   always_comb begin
      if (pitch_period_ff < pcp_pkg::PERIOD_BITS'(pcp_pkg::PERIOD_MIN)) begin
         period_eff = pcp_pkg::PERIOD_BITS'(pcp_pkg::PERIOD_MIN);
      end else if (pitch_period_ff > pcp_pkg::PERIOD_BITS'(pcp_pkg::PERIOD_MAX)) begin
         period_eff = pcp_pkg::PERIOD_BITS'(pcp_pkg::PERIOD_MAX);
      end else begin
         period_eff = pitch_period_ff;
      end
   end

   // ------------------------------------------------------------------
   // Window refill controller. A new period invalidates the tap window,
   // so the five taps of the next item are read back one per cycle.
   // ------------------------------------------------------------------
   pcp_pkg::ctl_state_type   ctl_state_ff, ctl_state_in;
   pcp_pkg::reload_step_type rl_step_ff, rl_step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= pcp_pkg::CTL_RUN;
         rl_step_ff   <= '0;
      end else begin
         ctl_state_ff <= ctl_state_in;
         rl_step_ff   <= rl_step_in;
      end
   end

   always_comb begin
      ctl_state_in = ctl_state_ff;
      rl_step_in   = rl_step_ff;
      unique case (ctl_state_ff)
         pcp_pkg::CTL_RUN: begin
            if (pitch_wr) begin
               ctl_state_in = pcp_pkg::CTL_RELOAD;
               rl_step_in   = '0;
            end
         end
         pcp_pkg::CTL_RELOAD: begin
            if (pitch_wr) begin
               rl_step_in = '0;               // new period again: start over
            end else if (rl_step_ff == pcp_pkg::RELOAD_LAST) begin
               ctl_state_in = pcp_pkg::CTL_RUN;
            end else begin
               rl_step_in = rl_step_ff + 1'b1;
            end
         end
         default: ctl_state_in = pcp_pkg::CTL_RUN;
      endcase
   end

   logic reloading;
   assign reloading = (ctl_state_ff == pcp_pkg::CTL_RELOAD);

   // ------------------------------------------------------------------
   // Pipeline handshake: stage 1 holds products, stage 2 the result.
   // ------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff;
   logic accept, s2_load;

   assign s2_load       = s1_vld_ff && (!s2_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !reloading && (!s1_vld_ff || s2_load);
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (s2_load) begin
            s1_vld_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            s2_vld_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Ring pointers and fill count. acc_ptr is the slot of the next item
   // to be accepted, wr_ptr the slot the next result is written to.
   // ------------------------------------------------------------------
   logic [AW-1:0] acc_ptr_ff, wr_ptr_ff;
   logic [AW-1:0] acc_ptr_inc, wr_ptr_inc;
   logic [CW-1:0] fill_cnt_ff;

   assign acc_ptr_inc = (acc_ptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : acc_ptr_ff + 1'b1;
   assign wr_ptr_inc  = (wr_ptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ptr_ff  <= '0;
         wr_ptr_ff   <= '0;
         fill_cnt_ff <= '0;
      end else begin
         if (accept) begin
            acc_ptr_ff <= acc_ptr_inc;
            if (fill_cnt_ff != CW'(HISTORY_DEPTH)) begin
               fill_cnt_ff <= fill_cnt_ff + 1'b1;
            end
         end
         if (s2_load) begin
            wr_ptr_ff <= wr_ptr_inc;
         end
      end
   end

   // ------------------------------------------------------------------
   // History read address. In steady state each accept prefetches the
   // newest tap y[k-P+2] of the following item k. During refill step i
   // reads y[k-P-2+i]. Addresses wrap with one compare and subtract.
   // A tap older than the first item ever accepted reads as zero.
   // ------------------------------------------------------------------
   logic [OW-1:0] rd_off, rd_sum;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic          rd_tap_vld;

   always_comb begin
      if (reloading) begin
         rd_off     = OW'(HISTORY_DEPTH) + OW'(rl_step_ff) - OW'(period_eff) - OW'(2);
         rd_tap_vld = (VW'(fill_cnt_ff) + VW'(rl_step_ff)) >= (VW'(period_eff) + VW'(2));
      end else begin
         rd_off     = OW'(HISTORY_DEPTH + 3) - OW'(period_eff);
         rd_tap_vld = (VW'(fill_cnt_ff) + VW'(3)) >= VW'(period_eff);
      end
      rd_sum = OW'(acc_ptr_ff) + rd_off;
      if (rd_sum >= OW'(HISTORY_DEPTH)) begin
         rd_sum = rd_sum - OW'(HISTORY_DEPTH);
      end
      rd_addr = rd_sum[AW-1:0];
   end

   assign rd_en = accept || reloading;

   // ------------------------------------------------------------------
   // History RAM: one write port (results), one registered read port.
   // ------------------------------------------------------------------
   logic signed [SB-1:0] hist_mem [HISTORY_DEPTH];
   logic signed [SB-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic signed [SB-1:0] result_val;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         hist_mem[wr_ptr_ff] <= result_val;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= rd_tap_vld;
      end
   end

   // ------------------------------------------------------------------
   // Tap window: y[n-P-2], y[n-P-1], y[n-P], y[n-P+1] for the next item;
   // the prefetched read data supplies y[n-P+2].
   // ------------------------------------------------------------------
   logic signed [SB-1:0] tap_win_ff [4];
   logic signed [SB-1:0] tap_new;
   logic                 shift_en;

   assign tap_new  = rd_vld_ff ? rd_data_ff : '0;
   assign shift_en = accept || (reloading && (rl_step_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            tap_win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         tap_win_ff[0] <= tap_win_ff[1];
         tap_win_ff[1] <= tap_win_ff[2];
         tap_win_ff[2] <= tap_win_ff[3];
         tap_win_ff[3] <= tap_new;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: symmetric pre-adds and the three gain multiplies.
   // ------------------------------------------------------------------
   logic signed [SB:0]    pair_inner, pair_outer;
   logic signed [PCW-1:0] prod_c_in, prod_c_ff;
   logic signed [PPW-1:0] prod_i_in, prod_i_ff;
   logic signed [PPW-1:0] prod_o_in, prod_o_ff;
   logic signed [SB-1:0]  x_ff;

   always_comb begin
      pair_inner = (SB+1)'(tap_win_ff[1]) + (SB+1)'(tap_win_ff[3]);
      pair_outer = (SB+1)'(tap_win_ff[0]) + (SB+1)'(tap_new);
      prod_c_in  = PCW'(gain_center_ff) * PCW'(tap_win_ff[2]);
      prod_i_in  = PPW'(gain_inner_ff) * PPW'(pair_inner);
      prod_o_in  = PPW'(gain_outer_ff) * PPW'(pair_outer);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff      <= req_bus.sample_in;
         prod_c_ff <= prod_c_in;
         prod_i_ff <= prod_i_in;
         prod_o_ff <= prod_o_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: exact sum, round half up at the Q1.23 grid, saturate.
   // ------------------------------------------------------------------
   logic signed [ACW-1:0] acc_sum;
   logic signed [RW-1:0]  acc_rnd;
   logic [RW-SB:0]        acc_top;
   logic signed [SB-1:0]  out_data_ff;

   always_comb begin
      acc_sum = (ACW'(x_ff) <<< pcp_pkg::GAIN_FRAC) + ACW'(prod_c_ff) + ACW'(prod_i_ff)
              + ACW'(prod_o_ff) + ROUND_BIAS;
      acc_rnd = acc_sum[ACW-1:pcp_pkg::GAIN_FRAC];
      acc_top = acc_rnd[RW-1:SB-1];
      if ((&acc_top) || !(|acc_top)) begin
         result_val = acc_rnd[SB-1:0];
      end else if (acc_rnd[RW-1]) begin
         result_val = {1'b1, {(SB-1){1'b0}}};
      end else begin
         result_val = {1'b0, {(SB-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         out_data_ff <= result_val;
      end
   end

   assign rsp_bus.valid      = s2_vld_ff;
   assign rsp_bus.sample_out = out_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `PCP_ASSERT_RST(a_no_accept_in_reload, clock, reset, reloading |-> !req_bus.ready)
   `PCP_ASSERT_RST(a_ptr_match_empty, clock, reset, !s1_vld_ff |-> (acc_ptr_ff == wr_ptr_ff))
   `PCP_ASSERT_RST(a_ptr_lead_one, clock, reset, s1_vld_ff |-> (acc_ptr_ff == wr_ptr_inc))
   `PCP_ASSERT_NEXT(a_load_shows_result, clock, reset, s2_load, rsp_bus.valid)
   `PCP_ASSERT_RST(a_fill_bounded, clock, reset, fill_cnt_ff <= CW'(HISTORY_DEPTH))

endmodule
